// File: design/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg: shared types and constants
// Widths, digit counts, the queue entry and the converter states used by the
// binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

    // Width of the input port and width of the number as converted.
    localparam int VALUE_W    = 32;
    localparam int VALUE_BITS = 32;

    // Decimal digits needed for VALUE_BITS bits: floor(bits * log10(2)) + 1.
    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam int CHAR_W = 6;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  is_zero;
    } q_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    // Reduce the port value modulo 2^VALUE_BITS, or zero-extend it.
    function automatic logic [VALUE_BITS-1:0] fit_value(input logic [VALUE_W-1:0] v);
        logic [VALUE_W+VALUE_BITS-1:0] wide;
        wide = {{VALUE_BITS{1'b0}}, v};
        return wide[VALUE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/b2da_front.sv
// ----------------------------------------------------------------------------
// b2da_front: input side
// Accepts values, marks zero values so the converter can skip the binary to
// BCD pass, and holds them in a short queue ahead of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_front
    import b2da_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [VALUE_W-1:0] value,
    output q_entry_t                head,
    output logic                    head_valid,
    input  wire logic               pop
);

    q_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              do_pop;
    q_entry_t          entry;

    assign in_stall   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push       = in_valid && !in_stall;
    assign head_valid = (count_reg != '0);
    assign do_pop     = pop && head_valid;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        entry.value   = fit_value(value);
        entry.is_zero = (entry.value == '0);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

// File: design/b2da_back.sv
// ----------------------------------------------------------------------------
// b2da_back: conversion and digit output
// Converts one queued value to BCD by shift-and-add-3, one bit per cycle,
// then walks the digits from the most significant end, dropping leading
// zeros, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_back
    import b2da_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire q_entry_t          head,
    input  wire logic              head_valid,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [CHAR_W-1:0]      digit_char,
    output logic                   last
);

    state_t                 state_reg;
    state_t                 state_next;
    logic [VALUE_BITS-1:0]  bin_reg;
    logic [VALUE_BITS-1:0]  bin_next;
    logic [BCD_W-1:0]       bcd_reg;
    logic [BCD_W-1:0]       bcd_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg;
    logic [DIG_CNT_W-1:0]   dig_cnt_next;
    logic                   started_reg;
    logic                   started_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [CHAR_W-1:0]      char_reg;
    logic [CHAR_W-1:0]      char_next;
    logic                   last_reg;
    logic                   last_next;
    logic                   out_free;
    logic [3:0]             top_digit;
    logic                   final_digit;
    logic                   emit;

    assign out_free    = !out_valid_reg || !out_stall;
    assign top_digit   = bcd_reg[BCD_W-1 -: 4];
    assign final_digit = (dig_cnt_reg == DIG_CNT_W'(1));
    // A leading zero is dropped, except that the final digit always goes out.
    assign emit        = started_reg || (top_digit != 4'd0) || final_digit;
    assign pop         = (state_reg == ST_IDLE) && head_valid;

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last       = last_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                             : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = head.is_zero ? ST_EMIT : ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (bit_cnt_reg == BIT_CNT_W'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && final_digit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                bin_next     = head.value;
                bcd_next     = '0;
                bit_cnt_next = BIT_CNT_W'(VALUE_BITS);
                dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
                started_next = 1'b0;
            end
            ST_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
                bin_next     = bin_reg << 1;
                bit_cnt_next = bit_cnt_reg - 1'b1;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    bcd_next     = bcd_reg << 4;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                    if (emit)
                    begin
                        started_next   = 1'b1;
                        out_valid_next = 1'b1;
                        char_next      = ASCII_ZERO + {2'b00, top_digit};
                        last_next      = final_digit;
                    end
                end
            end
            default:
            begin
                bin_next = bin_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        started_reg <= started_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

endmodule

`default_nettype wire

// File: design/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned binary to decimal ASCII text
// Each 32-bit input beat becomes one to ten output beats of ASCII digits,
// most significant first, leading zeros dropped, the final beat marked last.
// A nonzero value is taken from the queue, passes through the one-bit-
// per-cycle shift-and-add-3 loop, and then visits each of the ten BCD
// digit positions (including dropped leading zeros) at the output, holding
// while the output is stalled. A zero value skips the loop. A two-beat
// queue in front of the converter keeps taking input beats, until it is
// full, while a conversion is running.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii
    import b2da_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [VALUE_W-1:0] value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [CHAR_W-1:0]       digit_char,
    output logic                    last
);

    q_entry_t head;
    logic     head_valid;
    logic     pop;

    b2da_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    b2da_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last       (last)
    );

endmodule

`default_nettype wire
